### rtl/frfc_pkg.sv
// ----------------------------------------------------------------------------
// frfc_pkg
// Shared types and constants of the finite radix fraction check.
// ----------------------------------------------------------------------------
package frfc_pkg;

   // Field widths
   localparam int unsigned NUM_W   = 30;
   localparam int unsigned CNT_W   = 4;
   localparam int unsigned RADIX_W = 16;
   localparam int unsigned POW_W   = 50;

   // Limits of the check
   localparam int unsigned MAX_DIGITS       = 9;
   localparam int unsigned MAX_BASE_FACTORS = 8;

   // Reset value of the radix register
   localparam logic [RADIX_W-1:0] RADIX_RESET = 16'd10;

   // Reciprocals for exact division by small constants
   localparam logic [31:0] RECIP5_32  = 32'hCCCC_CCCD;  // n/5 = (n*R) >> 34
   localparam int unsigned RECIP5_SH  = 34;
   localparam logic [15:0] RECIP3_16  = 16'hAAAB;       // n/3 = (n*R) >> 17
   localparam int unsigned RECIP3_SH  = 17;
   localparam logic [15:0] RECIP5_16  = 16'hCCCD;       // n/5 = (n*R) >> 18
   localparam int unsigned RECIP5S_SH = 18;

   typedef logic [POW_W-1:0] pow_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;   // capture an input word and its range checks
      logic mul;    // form the quotient of the working value by five
      logic chk;    // replace the working value by its quotient
      logic emit;   // move the verdict into the output register
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic loop_done;  // out of range, or all places stripped of five
      logic rem_zero;   // working value divisible by five
   } dp_sts_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_CHK  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   // Ten to the power d
   function automatic pow_type pow10(input logic [CNT_W-1:0] d);
      pow_type p;
      case (d)
         4'd0:    p = POW_W'(64'd1);
         4'd1:    p = POW_W'(64'd10);
         4'd2:    p = POW_W'(64'd100);
         4'd3:    p = POW_W'(64'd1000);
         4'd4:    p = POW_W'(64'd10000);
         4'd5:    p = POW_W'(64'd100000);
         4'd6:    p = POW_W'(64'd1000000);
         4'd7:    p = POW_W'(64'd10000000);
         4'd8:    p = POW_W'(64'd100000000);
         4'd9:    p = POW_W'(64'd1000000000);
         4'd10:   p = POW_W'(64'd10000000000);
         4'd11:   p = POW_W'(64'd100000000000);
         4'd12:   p = POW_W'(64'd1000000000000);
         4'd13:   p = POW_W'(64'd10000000000000);
         4'd14:   p = POW_W'(64'd100000000000000);
         default: p = POW_W'(64'd1000000000000000);
      endcase
      return p;
   endfunction

endpackage

### rtl/frfc_ctrl.sv
// ----------------------------------------------------------------------------
// frfc_ctrl
// Sequencer of the check: accepts a word, steps the divide-by-five loop of
// the datapath and hands the verdict to the output register.
// ----------------------------------------------------------------------------
module frfc_ctrl
   import frfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output dp_cmd_type cmd,
   input  dp_sts_type sts
);

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;

   // Output register can take a word this cycle
   assign out_free = !out_valid_ff || rsp_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;

   // Decode datapath commands
   always_comb begin
      cmd.load = (state_ff == ST_IDLE) && req_tvalid;
      cmd.mul  = (state_ff == ST_MUL) && !sts.loop_done;
      cmd.chk  = (state_ff == ST_CHK) && sts.rem_zero;
      cmd.emit = (state_ff == ST_DONE) && out_free;
   end

   // Advance the sequence
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = sts.loop_done ? ST_DONE : ST_CHK;
         end
         ST_CHK: begin
            state_in = sts.rem_zero ? ST_MUL : ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Set on emit, drop when taken
   always_comb begin
      if (cmd.emit) out_valid_in = 1'b1;
      else if (rsp_tready) out_valid_in = 1'b0;
      else out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

### rtl/frfc_dp.sv
// ----------------------------------------------------------------------------
// frfc_dp
// Datapath of the check. The reduced denominator of n/10^d is 2^a * 5^b,
// with a > 0 unless 2^d divides n and b > 0 unless 5^d divides n. The
// powers of two are tested at once from the low bits; fives are stripped one
// per loop pass by a reciprocal multiply. The radix factors two and five
// count only when they fall among the allowed smallest primes of the radix.
// ----------------------------------------------------------------------------
module frfc_dp
   import frfc_pkg::*;
(
   input  logic               clock,
   input  dp_cmd_type         cmd,
   input  logic [NUM_W-1:0]   req_numerator,
   input  logic [CNT_W-1:0]   req_digit_count,
   input  logic [RADIX_W-1:0] radix,
   output dp_sts_type         sts,
   output logic               rsp_out_of_range,
   output logic               rsp_finite
);

   localparam int unsigned PROD_W  = NUM_W + 32;
   localparam int unsigned RPROD_W = RADIX_W + 16;

   logic [NUM_W-1:0]   cur_ff, cur_in;
   logic [NUM_W-1:0]   q_ff, q_in;
   logic [CNT_W-1:0]   left_ff, left_in;
   logic               oor_ff, need_two_ff, two_ok_ff, five_ok_ff;
   logic               rsp_oor_ff, rsp_finite_ff;

   logic               too_many, oor;
   logic [NUM_W-1:0]   two_mask;
   logic               need_two;
   logic [RPROD_W-1:0] r3_prod, r5_prod;
   logic [RADIX_W-1:0] r3_q, r5_q;
   logic               div3, div5, rad_even, rad_nz;
   logic [1:0]         small_cnt;
   logic [PROD_W-1:0]  prod;
   logic [NUM_W-1:0]   q_times5;
   logic               finite;

   // Range checks on the incoming word
   always_comb begin
      too_many = int'(req_digit_count) > int'(MAX_DIGITS);
      oor      = too_many || (req_numerator == '0)
               || (POW_W'(req_numerator) >= pow10(req_digit_count));
      two_mask = (NUM_W'(1) << req_digit_count) - NUM_W'(1);
      need_two = |(req_numerator & two_mask);
   end

   // Small prime factors of the radix
   always_comb begin
      r3_prod   = RPROD_W'(radix) * RPROD_W'(RECIP3_16);
      r5_prod   = RPROD_W'(radix) * RPROD_W'(RECIP5_16);
      r3_q      = RADIX_W'(r3_prod >> RECIP3_SH);
      r5_q      = RADIX_W'(r5_prod >> RECIP5S_SH);
      div3      = ((18'(r3_q) << 1) + 18'(r3_q)) == 18'(radix);
      div5      = ((18'(r5_q) << 2) + 18'(r5_q)) == 18'(radix);
      rad_nz    = (radix != '0);
      rad_even  = !radix[0];
      small_cnt = 2'(rad_even) + 2'(div3);
   end

   // Divide the working value by five
   assign prod     = PROD_W'(cur_ff) * PROD_W'(RECIP5_32);
   assign q_times5 = (q_ff << 2) + q_ff;

   always_comb begin
      q_in = cmd.mul ? NUM_W'(prod >> RECIP5_SH) : q_ff;
   end

   // Load on accept, replace by quotient on a clean divide
   always_comb begin
      cur_in  = cur_ff;
      left_in = left_ff;
      if (cmd.load) begin
         cur_in  = req_numerator;
         left_in = req_digit_count;
      end else if (cmd.chk) begin
         cur_in  = q_ff;
         left_in = left_ff - CNT_W'(1);
      end
   end

   assign sts.loop_done = oor_ff || (left_ff == '0);
   assign sts.rem_zero  = (q_times5 == cur_ff);

   // Verdict: remaining twos and fives must be covered by the radix
   assign finite = !oor_ff && (!need_two_ff || two_ok_ff)
                && ((left_ff == '0) || five_ok_ff);

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      left_ff <= left_in;
      q_ff    <= q_in;
      if (cmd.load) begin
         oor_ff      <= oor;
         need_two_ff <= need_two;
         two_ok_ff   <= rad_even && rad_nz;
         five_ok_ff  <= div5 && rad_nz && (int'(small_cnt) < int'(MAX_BASE_FACTORS));
      end
      if (cmd.emit) begin
         rsp_oor_ff    <= oor_ff;
         rsp_finite_ff <= finite;
      end
   end

   assign rsp_out_of_range = rsp_oor_ff;
   assign rsp_finite       = rsp_finite_ff;

endmodule

### rtl/finite_radix_fraction_check.sv
// ----------------------------------------------------------------------------
// finite_radix_fraction_check
// Tests whether numerator/10^digit_count terminates in the configured radix.
//
//   channel   ports                       word
//   input     req_tvalid/tready/tdata     numerator, digit_count
//   result    rsp_tvalid/tready/tdata     out_of_range, finite
//   config    csr_wr_en/csr_wr_data       radix
//
// After accept the sequencer alternates its MUL and CHK states for each of the k
// fives stripped from the numerator within the places, k in 0..digit_count, and
// leaves the loop in MUL when the places run out or the word is out of range, or
// in CHK on a remainder; it then waits in DONE for a free output register.
// One item is in work at a time; a finished result waits in the output
// register while the next item is accepted, and a second finished result
// holds the sequencer until the first one is taken.
// Reset clears the sequencer and output valid and sets radix to ten.
// ----------------------------------------------------------------------------
module finite_radix_fraction_check
   import frfc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [39:0]        req_tdata,    // [29:0] numerator, [33:30] digit_count
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,    // [0] out_of_range, [1] finite
   input  logic               csr_wr_en,
   input  logic [RADIX_W-1:0] csr_wr_data
);

   logic [RADIX_W-1:0] radix_ff, radix_in;
   dp_cmd_type         cmd;
   dp_sts_type         sts;
   logic               out_of_range, finite;

   // Radix register
   assign radix_in = csr_wr_en ? csr_wr_data : radix_ff;

   always_ff @(posedge clock) begin
      if (reset) radix_ff <= RADIX_RESET;
      else radix_ff <= radix_in;
   end

   frfc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   frfc_dp u_dp (
      .clock            (clock),
      .cmd              (cmd),
      .req_numerator    (req_tdata[NUM_W-1:0]),
      .req_digit_count  (req_tdata[NUM_W+CNT_W-1:NUM_W]),
      .radix            (radix_ff),
      .sts              (sts),
      .rsp_out_of_range (out_of_range),
      .rsp_finite       (finite)
   );

   assign rsp_tdata = {6'b0, finite, out_of_range};

   // An out of range word never reports finite
   a_oor_not_finite: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("out_of_range and finite both set");

   // One word at a time: no accept right after an accept
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted while busy");

   // Every emit from the sequencer presents a valid result word
   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_tvalid)
      else $error("emitted result not presented");

endmodule

### tb/finite_radix_fraction_check_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// finite_radix_fraction_check_test
// Self-checking bench for the finite radix fraction check. Decimal fractions
// go in as numerator and place count. A local predictor reduces each one,
// strips the prime factors of the current radix and queues the verdict. Each
// result word is compared against that queue. The run walks through radix
// settings that include zero, one, two and the all-ones value. Both
// handshakes idle at random, and the receiver once holds off long enough to
// back up the input.
// ----------------------------------------------------------------------------
module finite_radix_fraction_check_test;
   import frfc_pkg::*;

   localparam int RESET_CYCLES    = 10;
   localparam int DRAIN_CYCLES    = 30;
   localparam int STALL_LIMIT     = 4000;
   localparam int HOLD_CYCLES     = 300;
   localparam int ITEMS_PER_RADIX = 55;
   localparam int SWEEP_LEN       = 10;

   localparam logic [RADIX_W-1:0] RADIX_SWEEP [SWEEP_LEN] = '{
      16'd2, 16'd65535, 16'd0, 16'd1, 16'd3, 16'd30030, 16'd65521, 16'd16, 16'd250, 16'd10
   };

   typedef struct packed {
      logic finite;
      logic out_of_range;
   } verdict_type;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_tvalid  = 1'b0;
   logic               req_tready;
   logic [39:0]        req_tdata   = '0;
   logic               rsp_tvalid;
   logic               rsp_tready  = 1'b0;
   logic [7:0]         rsp_tdata;
   logic               csr_wr_en   = 1'b0;
   logic [RADIX_W-1:0] csr_wr_data = '0;

   verdict_type        pending_verdicts [$];
   logic [RADIX_W-1:0] radix_setting = RADIX_RESET;
   int                 mismatch_count = 0;
   int                 burst_left = 0;
   int                 idle_cycles = 0;
   logic               hold_request = 1'b0;
   int                 hold_left = 0;
   int                 stall_mode = 0;
   int                 mode_left = 0;
   int                 ready_phase = 0;

   finite_radix_fraction_check DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint unsigned ten_to(input int unsigned places);
      longint unsigned p;
      p = 1;
      for (int k = 0; k < places; k++)
         p = p * 10;
      return p;
   endfunction

   // Reduce the fraction, strip the radix primes from its denominator and
   // call it finite when nothing is left
   function automatic verdict_type predict_verdict(input logic [NUM_W-1:0]   num,
                                                   input logic [CNT_W-1:0]   places,
                                                   input logic [RADIX_W-1:0] base);
      verdict_type     v;
      longint unsigned den, a, b, t, r, p;
      int unsigned     used;
      v = '0;
      if (places > MAX_DIGITS) begin
         v.out_of_range = 1'b1;
         return v;
      end
      den = ten_to(places);
      if (num == 0 || num >= den) begin
         v.out_of_range = 1'b1;
         return v;
      end
      a = num;
      b = den;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      den = den / a;
      r = base;
      used = 0;
      for (p = 2; p * p <= r; p++) begin
         if (r % p == 0) begin
            if (used < MAX_BASE_FACTORS) begin
               while (den % p == 0)
                  den = den / p;
               used++;
            end
            while (r % p == 0)
               r = r / p;
         end
      end
      if (r > 1 && used < MAX_BASE_FACTORS) begin
         while (den % r == 0)
            den = den / r;
      end
      v.finite = (den == 1);
      return v;
   endfunction

   // Mostly in-range fractions with a chosen power-of-two/five common factor,
   // plus boundary and raw noise words
   task automatic make_fraction(output logic [NUM_W-1:0] num, output logic [CNT_W-1:0] places);
      int unsigned     pick, a, b, cnt;
      longint unsigned den, g, k;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         num = NUM_W'($urandom);
         places = CNT_W'($urandom);
      end else if (pick < 22) begin
         cnt = $urandom_range(0, MAX_DIGITS);
         den = ten_to(cnt);
         case ($urandom_range(0, 3))
            0:       num = '0;
            1:       num = NUM_W'(den);
            2:       num = NUM_W'(den - 1);
            default: num = NUM_W'(den + $urandom_range(0, 1000));
         endcase
         places = CNT_W'(cnt);
      end else begin
         cnt = $urandom_range(1, MAX_DIGITS);
         den = ten_to(cnt);
         a = $urandom_range(0, cnt);
         b = $urandom_range(0, cnt);
         g = 1;
         repeat (a) g = g * 2;
         repeat (b) g = g * 5;
         if (g >= den)
            g = 1;
         k = $urandom_range(1, int'((den - 1) / g));
         num = NUM_W'(g * k);
         places = CNT_W'(cnt);
      end
   endtask

   // Offer one word in bursts with random gaps; queue its verdict on accept
   task automatic send_word(input logic [NUM_W-1:0] num, input logic [CNT_W-1:0] places);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(0, 10);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, places, num};
      do @(posedge clock); while (!req_tready);
      pending_verdicts.push_back(predict_verdict(num, places, radix_setting));
      burst_left--;
   endtask

   // Drop valid and wait until every verdict has come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_radix(input logic [RADIX_W-1:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      radix_setting = value;
   endtask

   // Field extremes and boundaries at the reset radix
   task automatic test_range_edges();
      send_word(30'd0, 4'd0);
      send_word(30'd1, 4'd0);
      send_word(30'd0, 4'd9);
      send_word(30'd1, 4'd1);
      send_word(30'd5, 4'd1);
      send_word(30'd9, 4'd1);
      send_word(30'd10, 4'd1);
      send_word(30'd1, 4'd9);
      send_word(30'd999999999, 4'd9);
      send_word(30'd1000000000, 4'd9);
      send_word(30'h3FFFFFFF, 4'd9);
      send_word(30'h3FFFFFFF, 4'd15);
      send_word(30'd1, 4'd10);
      send_word(30'd123, 4'd15);
      send_word(30'd500000000, 4'd9);
      send_word(30'd25, 4'd2);
      send_word(30'd3, 4'd1);
      send_word(30'd33, 4'd2);
   endtask

   // Long receiver hold while the sender keeps offering words
   task automatic test_input_backpressure();
      logic [NUM_W-1:0] num;
      logic [CNT_W-1:0] places;
      hold_request = 1'b1;
      repeat (30) begin
         make_fraction(num, places);
         send_word(num, places);
      end
   endtask

   // Random fractions under each radix of the sweep and one random radix
   task automatic test_radix_sweep();
      logic [NUM_W-1:0] num;
      logic [CNT_W-1:0] places;
      for (int i = 0; i <= SWEEP_LEN; i++) begin
         if (i < SWEEP_LEN)
            set_radix(RADIX_SWEEP[i]);
         else
            set_radix(RADIX_W'($urandom_range(2, 65535)));
         repeat (ITEMS_PER_RADIX) begin
            make_fraction(num, places);
            send_word(num, places);
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_range_edges();
      test_input_backpressure();
      test_radix_sweep();
      wait_idle();
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Receiver: random stall modes, and a long hold when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            ready_phase++;
            case (stall_mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= (ready_phase % 5) < 2;
               default: rsp_tready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   // Compare each result word with the oldest queued verdict
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: result word with none expected, got finite=%0b out_of_range=%0b",
                     $time, rsp_tdata[1], rsp_tdata[0]);
            mismatch_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_tdata[0] !== want.out_of_range) begin
               $display("%0t: out_of_range mismatch, expected %0b, got %0b",
                        $time, want.out_of_range, rsp_tdata[0]);
               mismatch_count++;
            end
            if (rsp_tdata[1] !== want.finite) begin
               $display("%0t: finite mismatch, expected %0b, got %0b",
                        $time, want.finite, rsp_tdata[1]);
               mismatch_count++;
            end
         end
      end
   end

   // Abort when neither channel moves a word for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, pending_verdicts.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

endmodule

### finite_radix_fraction_check.f
rtl/frfc_pkg.sv
rtl/frfc_ctrl.sv
rtl/frfc_dp.sv
rtl/finite_radix_fraction_check.sv
tb/finite_radix_fraction_check_test.sv
